>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge, suspended while reset is asserted.
`define ASRT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");

// Property checked on every edge, including the reset cycles.
`define ASRT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

// Implication to the next cycle, suspended while reset is asserted.
`define ASRT_NEXT(lbl, clk, rstn, trig, cons) \
  `ASRT_PROP(lbl, clk, rstn, (trig) |=> (cons))

`endif

>>> hdl/slt_pkg.sv
package slt_pkg;

  // Sizes of the token counter and the keyword buffer.
  localparam int IDX_W       = 16;
  localparam int KW_MAX_LEN  = 5;
  localparam int LETTERS_W   = 8 * KW_MAX_LEN;
  localparam int WLEN_W      = $clog2(KW_MAX_LEN + 2);
  localparam int ACC_W       = 63;
  // Result fields carried on tdata; the token kind travels on tuser.
  localparam int RES_BITS    = 4 + ACC_W + 1 + 2 * IDX_W;
  localparam int TDATA_W     = ((RES_BITS + 7) / 8) * 8;
  localparam int NUM_KW      = 8;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Token kinds.
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_ADD   = 3'd1;
  localparam logic [2:0] KIND_SUB   = 3'd2;
  localparam logic [2:0] KIND_MUL   = 3'd3;
  localparam logic [2:0] KIND_DIV   = 3'd4;
  localparam logic [2:0] KIND_INTR  = 3'd5;
  localparam logic [2:0] KIND_PATCH = 3'd6;
  localparam logic [2:0] KIND_ERR   = 3'd7;

  // Intrinsic codes.
  localparam logic [3:0] IC_NONE = 4'd0;
  localparam logic [3:0] IC_DO    = 4'd5;
  localparam logic [3:0] IC_ELSE  = 4'd6;
  localparam logic [3:0] IC_END   = 4'd7;
  localparam logic [3:0] IC_EQ    = 4'd8;
  localparam logic [3:0] IC_LT    = 4'd9;
  localparam logic [3:0] IC_GT    = 4'd10;
  localparam logic [3:0] IC_NE    = 4'd11;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Keyword spellings, packed first letter highest; index is the intrinsic code.
  localparam logic [LETTERS_W-1:0] KW_TEXT [NUM_KW] = '{
    LETTERS_W'(40'h7072696e74),  // print
    LETTERS_W'(40'h64726f70),    // drop
    LETTERS_W'(40'h647570),      // dup
    LETTERS_W'(40'h6966),        // if
    LETTERS_W'(40'h7768696c65),  // while
    LETTERS_W'(40'h646f),        // do
    LETTERS_W'(40'h656c7365),    // else
    LETTERS_W'(40'h656e64)       // end
  };
  localparam logic [WLEN_W-1:0] KW_LEN [NUM_KW] = '{
    WLEN_W'(5), WLEN_W'(4), WLEN_W'(3), WLEN_W'(2),
    WLEN_W'(5), WLEN_W'(2), WLEN_W'(4), WLEN_W'(3)
  };

  // One result item.
  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [ACC_W-1:0] value;
    logic             ovf;
    logic [IDX_W-1:0] num;
    logic [IDX_W-1:0] target;
    logic             last;
  } res_t;

  // All results caused by one input item.
  typedef struct packed {
    res_t [2:0] r;
    logic [1:0] cnt;
  } res_set_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } kw_hit_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [3:0] code,
                                  input logic [ACC_W-1:0] value, input logic ovf,
                                  input logic [IDX_W-1:0] num,
                                  input logic [IDX_W-1:0] target);
    res_t r;
    r.kind   = kind;
    r.code   = code;
    r.value  = value;
    r.ovf    = ovf;
    r.num    = num;
    r.target = target;
    r.last   = 1'b0;
    return r;
  endfunction

  // Compare the buffered word against every keyword in parallel.
  function automatic kw_hit_t kw_lookup(input logic [LETTERS_W-1:0] letters,
                                        input logic [WLEN_W-1:0] len);
    kw_hit_t h;
    h.hit  = 1'b0;
    h.code = IC_NONE;
    for (int k = 0; k < NUM_KW; k++) begin
      if (letters == KW_TEXT[k] && len == KW_LEN[k]) begin
        h.hit  = 1'b1;
        h.code = 4'(k);
      end
    end
    return h;
  endfunction

endpackage

>>> hdl/slt_core.sv
module slt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                req_type,
  input  logic [7:0]          char_code,
  output slt_pkg::res_set_t   set
);

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_NUMBER  = 6'b000010,
    M_WORD    = 6'b000100,
    M_SLASH   = 6'b001000,
    M_BANG    = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_t;

  mode_t                              mode_r, mode_nxt;
  logic [slt_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic                               ovf_r, ovf_nxt;
  logic [slt_pkg::LETTERS_W-1:0]      letters_r, letters_nxt;
  logic [slt_pkg::WLEN_W-1:0]         wlen_r, wlen_nxt;
  logic [slt_pkg::IDX_W-1:0]          tc_r, tc_nxt;
  logic [slt_pkg::IDX_W-1:0]          last_do_r, last_do_nxt;
  logic [slt_pkg::IDX_W-1:0]          last_else_r, last_else_nxt;
  logic                               halt_r, halt_nxt;

  logic                               eol;
  logic                               is_digit, is_letter;
  logic [3:0]                         digit;
  logic [slt_pkg::ACC_W+3:0]          acc_wide, acc_x10;
  slt_pkg::kw_hit_t                   kw;

  // Character classes and the next decimal accumulator value.
  assign eol       = req_type;
  assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                     ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign digit     = char_code[3:0];
  assign acc_wide  = {4'b0, acc_r};
  assign acc_x10   = (acc_wide << 3) + (acc_wide << 1) +
                     (slt_pkg::ACC_W + 4)'(digit);
  assign kw        = slt_pkg::kw_lookup(letters_r, wlen_r);

  // One full lexer step: finish the pending token, then start on the character.
  always_comb begin
    logic       do_start;
    logic [1:0] n;
    logic [slt_pkg::IDX_W-1:0] self_idx;

    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    letters_nxt   = letters_r;
    wlen_nxt      = wlen_r;
    tc_nxt        = tc_r;
    last_do_nxt   = last_do_r;
    last_else_nxt = last_else_r;
    halt_nxt      = halt_r;
    set           = '0;
    n             = 2'd0;
    do_start      = 1'b0;
    self_idx      = tc_r;

    if (halt_r) begin
      set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_ERR, slt_pkg::IC_NONE, '0, 1'b0, tc_r, '0);
      n = n + 2'd1;
    end else begin
      unique case (mode_r)
        M_COMMENT: begin
          if (eol) begin
            mode_nxt = M_IDLE;
          end
        end
        M_NUMBER: begin
          if (!eol && is_digit) begin
            if (acc_x10[slt_pkg::ACC_W+3:slt_pkg::ACC_W] != 4'd0) begin
              acc_nxt = slt_pkg::ACC_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10[slt_pkg::ACC_W-1:0];
            end
          end else begin
            set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_INT, slt_pkg::IC_NONE, acc_r, ovf_r,
                                       tc_nxt, '0);
            n = n + 2'd1;
            tc_nxt   = tc_nxt + 1'b1;
            mode_nxt = M_IDLE;
            do_start = !eol;
          end
        end
        M_WORD: begin
          if (!eol && is_letter) begin
            if (wlen_r < slt_pkg::WLEN_W'(slt_pkg::KW_MAX_LEN)) begin
              letters_nxt = {letters_r[slt_pkg::LETTERS_W-9:0], char_code};
              wlen_nxt    = wlen_r + 1'b1;
            end else begin
              wlen_nxt = slt_pkg::WLEN_W'(slt_pkg::KW_MAX_LEN + 1);
            end
          end else begin
            mode_nxt = M_IDLE;
            if (!kw.hit) begin
              // Unknown word: report an error and stop lexing until reset.
              halt_nxt = 1'b1;
              set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_ERR, slt_pkg::IC_NONE, '0, 1'b0,
                                         tc_r, '0);
              n = n + 2'd1;
            end else begin
              self_idx = tc_r;
              set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_INTR, kw.code, '0, 1'b0,
                                         self_idx, '0);
              n = n + 2'd1;
              tc_nxt = tc_r + 1'b1;
              if (kw.code == slt_pkg::IC_DO) begin
                last_do_nxt = self_idx;
              end else if (kw.code == slt_pkg::IC_ELSE) begin
                last_else_nxt = self_idx;
                set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_PATCH, slt_pkg::IC_NONE, '0, 1'b0,
                                           last_do_r, self_idx + 1'b1);
                n = n + 2'd1;
              end else if (kw.code == slt_pkg::IC_END) begin
                set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_PATCH, slt_pkg::IC_NONE, '0, 1'b0,
                                           last_else_r, self_idx);
                n = n + 2'd1;
              end
              do_start = !eol;
            end
          end
        end
        M_SLASH: begin
          if (!eol && char_code == slt_pkg::CH_SLASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_DIV, slt_pkg::IC_NONE, '0, 1'b0,
                                       tc_nxt, '0);
            n = n + 2'd1;
            tc_nxt   = tc_nxt + 1'b1;
            mode_nxt = M_IDLE;
            do_start = !eol;
          end
        end
        M_BANG: begin
          mode_nxt = M_IDLE;
          if (!eol) begin
            if (char_code == slt_pkg::CH_EQ) begin
              set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_INTR, slt_pkg::IC_NE, '0, 1'b0,
                                         tc_nxt, '0);
              n = n + 2'd1;
              tc_nxt = tc_nxt + 1'b1;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        M_IDLE: begin
          do_start = !eol;
        end
        default: begin
          mode_nxt = M_IDLE;
          do_start = !eol;
        end
      endcase

      // Handle the character as the first one of a new token.
      if (do_start) begin
        mode_nxt = M_IDLE;
        priority if (is_digit) begin
          mode_nxt = M_NUMBER;
          acc_nxt  = slt_pkg::ACC_W'(digit);
          ovf_nxt  = 1'b0;
        end else if (is_letter) begin
          mode_nxt    = M_WORD;
          letters_nxt = slt_pkg::LETTERS_W'(char_code);
          wlen_nxt    = slt_pkg::WLEN_W'(1);
        end else if (char_code == slt_pkg::CH_SLASH) begin
          mode_nxt = M_SLASH;
        end else if (char_code == slt_pkg::CH_BANG) begin
          mode_nxt = M_BANG;
        end else if (char_code == slt_pkg::CH_PLUS || char_code == slt_pkg::CH_MINUS ||
                     char_code == slt_pkg::CH_STAR || char_code == slt_pkg::CH_EQ ||
                     char_code == slt_pkg::CH_LT || char_code == slt_pkg::CH_GT) begin
          set.r[n] = slt_pkg::mk_res(slt_pkg::KIND_INTR, slt_pkg::IC_NONE, '0, 1'b0,
                                     tc_nxt, '0);
          priority if (char_code == slt_pkg::CH_PLUS) begin
            set.r[n].kind = slt_pkg::KIND_ADD;
          end else if (char_code == slt_pkg::CH_MINUS) begin
            set.r[n].kind = slt_pkg::KIND_SUB;
          end else if (char_code == slt_pkg::CH_STAR) begin
            set.r[n].kind = slt_pkg::KIND_MUL;
          end else if (char_code == slt_pkg::CH_EQ) begin
            set.r[n].code = slt_pkg::IC_EQ;
          end else if (char_code == slt_pkg::CH_LT) begin
            set.r[n].code = slt_pkg::IC_LT;
          end else begin
            set.r[n].code = slt_pkg::IC_GT;
          end
          n = n + 2'd1;
          tc_nxt = tc_nxt + 1'b1;
        end else begin
          mode_nxt = M_IDLE;
        end
      end
    end

    // Mark the final result of this item.
    if (n != 2'd0) begin
      set.r[n - 2'd1].last = 1'b1;
    end
    set.cnt = n;
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      letters_r   <= '0;
      wlen_r      <= '0;
      tc_r        <= '0;
      last_do_r   <= '0;
      last_else_r <= '0;
      halt_r      <= 1'b0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      letters_r   <= letters_nxt;
      wlen_r      <= wlen_nxt;
      tc_r        <= tc_nxt;
      last_do_r   <= last_do_nxt;
      last_else_r <= last_else_nxt;
      halt_r      <= halt_nxt;
    end
  end

endmodule

>>> hdl/slt_outq.sv
module slt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  slt_pkg::res_set_t  set,
  input  logic               out_ready,
  output slt_pkg::res_t      head,
  output logic               out_valid,
  output logic               room
);

  slt_pkg::res_t [2:0] q_r, q_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = q_r[0];
  assign pop       = out_valid && out_ready;
  // A new set may load once the last waiting item leaves in this cycle.
  assign room      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  // Load a whole result set, or shift one item out toward the head.
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = set.r;
      cnt_nxt = set.cnt;
    end else if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

>>> hdl/stack_language_tokenizer.sv
// Streaming tokenizer for a small stack language.
// Input channel (in_*): one item per source character; in_tuser high marks an
// end of line, otherwise in_tdata carries the character byte.
// Output channel (out_*): token items; out_tuser carries the token kind and
// out_tlast marks the final item caused by one input item. An input item
// causes zero to three output items.
// An accepted item is registered in the input register; its results load
// into the output queue when it steps the lexer, and show from there.
// Throughput: one input item per cycle while each item causes at most one
// result and the receiver is ready. An item causing two or three results
// holds the input until its last result leaves, since the
// three-entry output queue drains one result per cycle while the receiver
// is ready, and a new set loads in the cycle its last waiting item leaves.
// A stalled receiver holds out_tvalid and out_tdata; in_tready drops once the
// input register holds an item that cannot yet load into the queue.
// Reset (synchronous, rst_n low) clears the lexer state, the token count and
// the error halt, and empties both channels; no clearing pass is needed.
module stack_language_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_code
  input  logic                        in_tuser,   // [0] req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [3:0] intrinsic_code, [66:4] int_value, [67] value_overflow,
  // [83:68] token_number, [99:84] pair_target, rest zero
  output logic [slt_pkg::TDATA_W-1:0] out_tdata,
  output logic [2:0]                  out_tuser,  // [2:0] token_kind
  output logic                        out_tlast   // last_of_run
);

  logic              in_valid_r, in_valid_nxt;
  logic              in_type_r;
  logic [7:0]        in_char_r;
  logic              room;
  logic              step;
  slt_pkg::res_set_t set;
  slt_pkg::res_t     head;

  // The registered item steps the lexer when the queue can take its results.
  assign step      = in_valid_r && room;
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_type_r <= in_tuser;
      in_char_r <= in_tdata;
    end
  end

  slt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req_type  (in_type_r),
    .char_code (in_char_r),
    .set       (set)
  );

  slt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .set       (set),
    .out_ready (out_tready),
    .head      (head),
    .out_valid (out_tvalid),
    .room      (room)
  );

  // Pack the head result onto the output bus.
  assign out_tdata = {{(slt_pkg::TDATA_W - slt_pkg::RES_BITS){1'b0}},
                      head.target, head.num, head.ovf, head.value, head.code};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> hdl/slt_checker.sv
`include "assert_macros.svh"

module slt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [slt_pkg::TDATA_W-1:0] out_tdata,
  input logic [2:0]                  out_tuser,
  input logic                        out_tlast
);

  logic err_kind;

  assign err_kind = (out_tuser == slt_pkg::KIND_ERR);

  // Reset empties both sides: no result, input open.
  `ASRT_ALWAYS(a_reset_empty, clk, (!rst_n) |=> (!out_tvalid && in_tready))

  // A stalled result holds its payload.
  `ASRT_NEXT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready),
             (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))

  // An error result is always the last one for its input item.
  `ASRT_PROP(a_err_last, clk, rst_n, (out_tvalid && err_kind) |-> out_tlast)

  // Once an error is delivered, every later result is an error too.
  `ASRT_NEXT(a_err_sticky, clk, rst_n, (out_tvalid && out_tready && err_kind),
             (!out_tvalid || err_kind))

  // Literal values appear on integer tokens only.
  `ASRT_PROP(a_value_kind, clk, rst_n,
             (out_tvalid && (out_tuser != slt_pkg::KIND_INT)) |->
             ((out_tdata[66:4] == '0) && !out_tdata[67]))

endmodule

bind stack_language_tokenizer slt_checker u_slt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/sv/stack_language_tokenizer_checker.sv
`timescale 1ns / 1ps

module stack_language_tokenizer_checker
  import slt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] char_code
  input  logic                in_tuser,   // [0] req_type
  input  logic                out_tvalid,
  input  logic                out_tready,
  // [3:0] intrinsic_code, [66:4] int_value, [67] value_overflow,
  // [83:68] token_number, [99:84] pair_target
  input  logic [TDATA_W-1:0]  out_tdata,
  input  logic [2:0]          out_tuser,  // [2:0] token_kind
  input  logic                out_tlast,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  // Keyword codes that the package leaves unnamed.
  localparam logic [3:0] KW_PRINT = 4'd0;
  localparam logic [3:0] KW_DROP  = 4'd1;
  localparam logic [3:0] KW_DUP   = 4'd2;
  localparam logic [3:0] KW_IF    = 4'd3;
  localparam logic [3:0] KW_WHILE = 4'd4;

  typedef enum logic [2:0] {
    LEX_IDLE, LEX_NUMBER, LEX_WORD, LEX_SLASH, LEX_BANG, LEX_COMMENT
  } lex_mode_t;

  typedef struct {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [ACC_W-1:0] value;
    logic             ovf;
    logic [IDX_W-1:0] num;
    logic [IDX_W-1:0] target;
    logic             last;
  } token_t;

  // Lexer state as the block should hold it.
  lex_mode_t            mode;
  logic [ACC_W-1:0]     accum;
  logic                 accum_sat;
  logic [LETTERS_W-1:0] letters;
  logic [2:0]           wlen;
  logic [IDX_W-1:0]     tok_count;
  logic [IDX_W-1:0]     last_do;
  logic [IDX_W-1:0]     last_else;
  logic                 halted;

  token_t run_tokens[$];
  token_t expected_tokens[$];
  int     errors = 0;
  int     outstanding = 0;
  int     results_checked = 0;

  assign fail_count = errors;
  assign pending    = outstanding;
  assign checked    = results_checked;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Letters are packed first letter highest, so the value alone names the word.
  function automatic bit keyword_lookup(input logic [LETTERS_W-1:0] w,
                                        output logic [3:0] code);
    code = IC_NONE;
    case (w)
      "print": code = KW_PRINT;
      "drop":  code = KW_DROP;
      "dup":   code = KW_DUP;
      "if":    code = KW_IF;
      "while": code = KW_WHILE;
      "do":    code = IC_DO;
      "else":  code = IC_ELSE;
      "end":   code = IC_END;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic emit(logic [2:0] kind, logic [3:0] code, logic [ACC_W-1:0] value,
                      logic ovf, logic [IDX_W-1:0] num, logic [IDX_W-1:0] target);
    token_t t;
    t.kind   = kind;
    t.code   = code;
    t.value  = value;
    t.ovf    = ovf;
    t.num    = num;
    t.target = target;
    t.last   = 1'b0;
    run_tokens.insert(run_tokens.size(), t);
  endtask

  // A numbered token takes the running count, which then advances.
  task automatic emit_numbered(logic [2:0] kind, logic [3:0] code,
                               logic [ACC_W-1:0] value, logic ovf);
    emit(kind, code, value, ovf, tok_count, '0);
    tok_count = tok_count + 1'b1;
  endtask

  // Ends a letter run: a keyword token and its patch, or the sticky error.
  task automatic close_word(output bit ok);
    logic [3:0]       code;
    logic [IDX_W-1:0] self_num;
    bit               hit;
    hit = keyword_lookup(letters, code);
    if (wlen > KW_MAX_LEN) hit = 1'b0;
    self_num = tok_count;
    mode = LEX_IDLE;
    ok = hit;
    if (!hit) begin
      halted = 1'b1;
      emit(KIND_ERR, IC_NONE, '0, 1'b0, tok_count, '0);
      return;
    end
    emit_numbered(KIND_INTR, code, '0, 1'b0);
    if (code == IC_DO) begin
      last_do = self_num;
    end else if (code == IC_ELSE) begin
      last_else = self_num;
      emit(KIND_PATCH, IC_NONE, '0, 1'b0, last_do, self_num + 1'b1);
    end else if (code == IC_END) begin
      emit(KIND_PATCH, IC_NONE, '0, 1'b0, last_else, self_num);
    end
  endtask

  // Handles a character seen from the idle state.
  task automatic begin_char(logic [7:0] c);
    mode = LEX_IDLE;
    if (is_digit(c)) begin
      mode      = LEX_NUMBER;
      accum     = ACC_W'(c - "0");
      accum_sat = 1'b0;
    end else if (is_letter(c)) begin
      mode    = LEX_WORD;
      letters = LETTERS_W'(c);
      wlen    = 3'd1;
    end else if (c == CH_SLASH) begin
      mode = LEX_SLASH;
    end else if (c == CH_BANG) begin
      mode = LEX_BANG;
    end else if (c == CH_PLUS) begin
      emit_numbered(KIND_ADD, IC_NONE, '0, 1'b0);
    end else if (c == CH_MINUS) begin
      emit_numbered(KIND_SUB, IC_NONE, '0, 1'b0);
    end else if (c == CH_STAR) begin
      emit_numbered(KIND_MUL, IC_NONE, '0, 1'b0);
    end else if (c == CH_EQ) begin
      emit_numbered(KIND_INTR, IC_EQ, '0, 1'b0);
    end else if (c == CH_LT) begin
      emit_numbered(KIND_INTR, IC_LT, '0, 1'b0);
    end else if (c == CH_GT) begin
      emit_numbered(KIND_INTR, IC_GT, '0, 1'b0);
    end
  endtask

  // Works out every token caused by one accepted item and queues them.
  task automatic lex_item(logic eol, logic [7:0] c);
    bit          ok;
    logic [63:0] digit;
    token_t      t;
    run_tokens.delete();
    if (halted) begin
      emit(KIND_ERR, IC_NONE, '0, 1'b0, tok_count, '0);
    end else begin
      case (mode)
        LEX_COMMENT: begin
          if (eol) mode = LEX_IDLE;
        end
        LEX_NUMBER: begin
          if (!eol && is_digit(c)) begin
            digit = 64'(c - "0");
            if (64'(accum) > (64'(ACC_MAX) - digit) / 64'd10) begin
              accum     = ACC_MAX;
              accum_sat = 1'b1;
            end else begin
              accum = ACC_W'(64'(accum) * 64'd10 + digit);
            end
          end else begin
            emit_numbered(KIND_INT, IC_NONE, accum, accum_sat);
            mode = LEX_IDLE;
            if (!eol) begin_char(c);
          end
        end
        LEX_WORD: begin
          if (!eol && is_letter(c)) begin
            if (wlen < KW_MAX_LEN) begin
              letters = {letters[LETTERS_W-9:0], c};
              wlen    = wlen + 1'b1;
            end else begin
              wlen = 3'(KW_MAX_LEN + 1);
            end
          end else begin
            close_word(ok);
            if (ok && !eol) begin_char(c);
          end
        end
        LEX_SLASH: begin
          if (!eol && c == CH_SLASH) begin
            mode = LEX_COMMENT;
          end else begin
            emit_numbered(KIND_DIV, IC_NONE, '0, 1'b0);
            mode = LEX_IDLE;
            if (!eol) begin_char(c);
          end
        end
        LEX_BANG: begin
          mode = LEX_IDLE;
          if (!eol) begin
            if (c == CH_EQ) emit_numbered(KIND_INTR, IC_NE, '0, 1'b0);
            else begin_char(c);
          end
        end
        default: begin
          mode = LEX_IDLE;
          if (!eol) begin_char(c);
        end
      endcase
    end
    // The final token of the run carries the last flag.
    foreach (run_tokens[i]) begin
      t      = run_tokens[i];
      t.last = (i == run_tokens.size() - 1);
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
  endtask

  // Compares one accepted result with the oldest expected token.
  task automatic check_result();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d arrived with nothing expected",
                                out_tuser));
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("token_kind",     64'(out_tuser),        64'(want.kind));
    compare_field("intrinsic_code", 64'(out_tdata[3:0]),   64'(want.code));
    compare_field("int_value",      64'(out_tdata[66:4]),  64'(want.value));
    compare_field("value_overflow", 64'(out_tdata[67]),    64'(want.ovf));
    compare_field("token_number",   64'(out_tdata[83:68]), 64'(want.num));
    compare_field("pair_target",    64'(out_tdata[99:84]), 64'(want.target));
    compare_field("last_of_run",    64'(out_tlast),        64'(want.last));
    results_checked++;
  endtask

  // Results are checked before new items are predicted, so that a result can
  // never be matched against an item accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      mode      = LEX_IDLE;
      accum     = '0;
      accum_sat = 1'b0;
      letters   = '0;
      wlen      = '0;
      tok_count = '0;
      last_do   = '0;
      last_else = '0;
      halted    = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) lex_item(in_tuser, in_tdata);
    end
    outstanding = expected_tokens.size();
  end

endmodule

>>> tb/sv/stack_language_tokenizer_test.sv
`timescale 1ns / 1ps

module stack_language_tokenizer_test;
  import slt_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 90;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tready = 1'b0;
  logic               in_tready;
  logic               out_tvalid;
  logic [TDATA_W-1:0] out_tdata;
  logic [2:0]         out_tuser;
  logic               out_tlast;

  int fail_count;
  int pending;
  int checked;

  typedef struct packed {
    logic       eol;
    logic [7:0] code;
  } src_item_t;

  src_item_t src_q[$];
  bit        after_letter = 1'b0;
  int        idle_pct     = 0;
  int        stall_pct    = 0;
  int        hold_kick    = 0;
  int        hold_seen    = 0;
  int        hold_left    = 0;
  int        quiet_cycles = 0;
  int        items_sent   = 0;
  string     kw_spellings [8] = '{"print", "drop", "dup", "if", "while", "do", "else", "end"};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  stack_language_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  stack_language_tokenizer_checker token_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_kick) begin
      hold_seen  <= hold_kick;
      hold_left  <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("stack_language_tokenizer_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit is_letter_byte(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function void add_char(logic [7:0] c);
    src_q.insert(src_q.size(), {1'b0, c});
    after_letter = is_letter_byte(c);
  endfunction

  // The byte beside an end of line is ignored, so it is left random.
  function void add_eol();
    src_q.insert(src_q.size(), {1'b1, 8'($urandom)});
    after_letter = 1'b0;
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // Mostly short literals, with the saturation boundary and long runs mixed in.
  function void add_number();
    int n;
    case ($urandom_range(9))
      0: add_text("9223372036854775807");
      1: add_text("9223372036854775808");
      2: begin
        n = $urandom_range(26, 20);
        repeat (n) add_char(8'("0" + $urandom_range(9)));
      end
      3: add_text("0");
      default: begin
        n = $urandom_range(6, 1);
        repeat (n) add_char(8'("0" + $urandom_range(9)));
      end
    endcase
  endfunction

  // Letters only ever appear inside keywords or comments, so no unknown word
  // can halt the block before the last phase.
  function void add_random_token();
    int         pick;
    int         k;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 28) begin
      k = $urandom_range(11);
      if (k >= 8) k = 5 + (k % 3);
      if (after_letter) add_char(" ");
      add_text(kw_spellings[k]);
    end else if (pick < 46) begin
      add_number();
    end else if (pick < 66) begin
      case ($urandom_range(8))
        0: add_char(CH_PLUS);
        1: add_char(CH_MINUS);
        2: add_char(CH_STAR);
        3: add_char(CH_EQ);
        4: add_char(CH_LT);
        5: add_char(CH_GT);
        6: add_text("!=");
        7: add_char(CH_BANG);
        default: add_char(CH_SLASH);
      endcase
    end else if (pick < 73) begin
      add_text("//");
      repeat ($urandom_range(6)) add_char(8'($urandom));
      add_eol();
    end else if (pick < 86) begin
      case ($urandom_range(2))
        0: add_char(" ");
        1: add_char("\t");
        default: add_char("\n");
      endcase
    end else if (pick < 92) begin
      add_eol();
    end else begin
      do c = 8'($urandom); while (is_letter_byte(c));
      add_char(c);
    end
  endfunction

  // Offers one item and holds it until the block takes it.
  task automatic send_item(src_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.eol;
    in_tdata  <= it.code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_queue();
    while (src_q.size() > 0) send_item(src_q.pop_front());
  endtask

  // The sender goes quiet until every expected result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic run_random(int idle, int stall, int count);
    idle_pct  <= idle;
    stall_pct <= stall;
    while (src_q.size() < count) add_random_token();
    send_queue();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Patches before any do or else, every operator, lone bang, slash lookahead.
    add_text("end else/+-*=<>!=!-!");
    add_eol();
    add_text("/ /");
    add_eol();
    add_text("0");
    add_eol();
    send_queue();

    // Random token streams under each mix of sender gaps and receiver stalls.
    run_random(0, 0, PHASE_ITEMS);
    run_random(64, 0, PHASE_ITEMS);
    run_random(0, 64, PHASE_ITEMS);
    run_random(36, 36, PHASE_ITEMS);

    // Long receiver hold while dense multi-result items keep arriving.
    idle_pct  <= 0;
    stall_pct <= 0;
    hold_kick <= hold_kick + 1;
    if (after_letter) add_char(" ");
    repeat (4) add_text("do else+end*");
    add_eol();
    send_queue();
    wait_drained();

    // An overlong word halts the block; every later item gives the error.
    idle_pct  <= 36;
    stall_pct <= 36;
    add_text("dup whiles");
    add_eol();
    repeat (10) begin
      if ($urandom_range(1) == 1) add_eol();
      else add_char(8'($urandom));
    end
    send_queue();
    wait_drained();
    repeat (8) @(negedge clk);

    $display("Sent %0d items through free, gapped, stalled and mixed traffic and a long hold.",
             items_sent);
    $display("Checked %0d result items, ending with the halt after an overlong word.", checked);
    if (fail_count == 0) begin
      $display("stack_language_tokenizer_test: clean");
    end else begin
      $display("stack_language_tokenizer_test: errors");
    end
    $finish;
  end

endmodule
